// ===== hdl/square_voice_pcm_mixer_top_defines.svh =====
// Assertion helpers shared by the mixer RTL.
`ifndef SQUARE_VOICE_PCM_MIXER_TOP_DEFINES_SVH
`define SQUARE_VOICE_PCM_MIXER_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SVM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define SVM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/svm_pkg.sv =====
package svm_pkg;

  localparam int FIFO_DEPTH  = 4096;
  localparam int PTR_W       = $clog2(FIFO_DEPTH);
  localparam int CNT_W       = PTR_W + 1;
  localparam int VOICE_COUNT = 4;
  localparam int VIDX_W      = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;

  localparam int SAMPLE_W = 16;
  localparam int FREQ_W   = 16;
  localparam int DUR_W    = 16;
  localparam int TVOL_W   = 8;
  localparam int VOL_W    = 7;
  localparam int RATE_W   = 16;
  localparam int USED_W   = 2;
  localparam int OP_W     = 2;

  localparam int PHASE_W = 32;
  localparam int LEFT_W  = 22;
  localparam int AMP_W   = 13;
  localparam int MIX_W   = 18;

  localparam int IN_DATA_W  = ((SAMPLE_W + FREQ_W + DUR_W + TVOL_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((SAMPLE_W + 1 + USED_W + CNT_W + 7) / 8) * 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Serial arithmetic units.
  localparam int MUL_W     = 32;
  localparam int MUL_BW    = 16;
  localparam int MUL_CNT_W = 5;
  localparam int DIV_W     = 48;
  localparam int DIVR_W    = 16;
  localparam int DIV_CNT_W = 6;

  localparam int VOL_RESET  = 50;
  localparam int RATE_RESET = 16000;
  localparam int VOL_MAX    = 100;
  localparam int PCT_DIV    = 100;
  localparam int MS_PER_S   = 1000;
  localparam int AMP_DIV    = 10000;
  localparam int AMP_BASE   = 32767 / 5;

  // Step counts: each covers the significant bits of that operand.
  localparam int PUSH_MUL_STEPS = VOL_W;
  localparam int PUSH_DIV_STEPS = 22;
  localparam int STEP_DIV_STEPS = DIV_W;
  localparam int LEN_MUL_STEPS  = RATE_W;
  localparam int LEN_DIV_STEPS  = 32;
  localparam int AMP_MUL_STEPS  = VOL_W;
  localparam int AMP_MUL2_STEPS = 13;
  localparam int AMP_DIV_STEPS  = 26;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH  = 2'd0,
    OP_TONE  = 2'd1,
    OP_TICK  = 2'd2,
    OP_CLEAR = 2'd3
  } svm_op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VOLUME = 2'd0,
    CFG_RATE   = 2'd1,
    CFG_ACTIVE = 2'd2
  } svm_cfg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DECODE,
    ST_PUSH_MUL,
    ST_PUSH_DIV,
    ST_PUSH_WR,
    ST_TONE_SCAN,
    ST_TONE_STEP,
    ST_TONE_LMUL,
    ST_TONE_LDIV,
    ST_TONE_AMUL,
    ST_TONE_AMUL2,
    ST_TONE_ADIV,
    ST_TONE_WR,
    ST_TICK_RD,
    ST_TICK_LD,
    ST_TICK_MIX,
    ST_FIN
  } svm_state_t;

  typedef struct packed {
    logic              clear;
    logic              load;
    logic              tick;
    logic [VIDX_W-1:0] rd_idx;
    logic [VIDX_W-1:0] wr_idx;
    logic [PHASE_W-1:0] step;
    logic [LEFT_W-1:0] left;
    logic [AMP_W-1:0]  amp;
  } svm_vcmd_t;

endpackage

// ===== hdl/square_voice_pcm_mixer_top.sv =====
// Square-voice PCM mixer.
// Items enter on the in_ stream: in_tuser carries the operation (push, tone,
// tick, clear), in_tdata the sample and tone fields. Every item gives exactly
// one word on the out_ stream with the mixed sample, the accepted flag, the
// voice used and the FIFO level after the item. Registers are written on the
// cfg_ channel while the block is idle (cfg_ready is high only then).
// Items are handled one at a time through a shared bit-serial multiplier and
// a shared restoring divider, one bit per cycle; they set the latency.
// Push runs a 7-bit multiply and a 22-step divide; tone runs a voice scan,
// a 48-step phase-step divide and the length and amplitude products; tick
// reads the FIFO and walks the voices; clear goes straight to the result.
// in_tready returns in the same cycle as the result is loaded into the output
// register, so the next item is taken while the last word still waits.
// When the receiver stalls, a finished item waits in its last state until the
// output register frees up. The sample FIFO is one 4096 x 16 RAM with a
// registered read. Reset empties the FIFO and all voices and sets volume 50,
// sample rate 16000 and active off; RAM contents are not cleared.
`include "square_voice_pcm_mixer_top_defines.svh"

module square_voice_pcm_mixer_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // pcm_sample[15:0], tone_freq_hz[31:16], tone_duration_ms[47:32],
  // tone_volume[55:48]
  input  logic [svm_pkg::IN_DATA_W-1:0]    in_tdata,
  // op[1:0]
  input  logic [svm_pkg::OP_W-1:0]         in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // mixed_sample[15:0], accepted[16], voice_used[18:17], fifo_level[31:19]
  output logic [svm_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [svm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [svm_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import svm_pkg::*;

  svm_state_t state_r, state_nxt;

  svm_op_t             op_r;
  logic [SAMPLE_W-1:0] pcm_r;
  logic [FREQ_W-1:0]   freq_r;
  logic [DUR_W-1:0]    dur_r;
  logic [TVOL_W-1:0]   tvol_r;

  logic [VOL_W-1:0]  vol_r;
  logic [RATE_W-1:0] rate_r;
  logic              active_r;

  logic [PTR_W-1:0] rd_ptr_r, wr_ptr_r;
  logic [CNT_W-1:0] count_r;

  logic [VIDX_W-1:0]  vidx_r, sel_r;
  logic [LEFT_W-1:0]  best_r;
  logic [PHASE_W-1:0] step_res_r;
  logic [LEFT_W-1:0]  len_res_r;
  logic               had_r;
  logic signed [MIX_W-1:0] mix_r;
  logic               res_acc_r;
  logic [USED_W-1:0]  res_used_r;

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic in_acc, cfg_acc, out_free, vidx_last, fifo_full, fifo_empty, tone_ok;
  logic empty_go;
  logic [VOL_W-1:0]    cfg_vol_in;
  logic [SAMPLE_W:0]   pcm_mag;
  logic [SAMPLE_W-1:0] push_q, push_val;
  logic [VOL_W-1:0]    tvol_clamp;
  logic [LEFT_W-1:0]   len_sat;
  logic signed [MIX_W-1:0] amp_ext, contrib;
  logic [SAMPLE_W-1:0] mix_clamped;

  logic                 mul_go, mul_done;
  logic [MUL_W-1:0]     mul_a, mul_p;
  logic [MUL_BW-1:0]    mul_b;
  logic [MUL_CNT_W-1:0] mul_steps;
  logic                 div_go, div_done;
  logic [DIV_W-1:0]     div_n, div_q;
  logic [DIVR_W-1:0]    div_d;
  logic [DIV_CNT_W-1:0] div_steps;

  logic                ram_we, ram_re;
  logic [SAMPLE_W-1:0] ram_q;

  svm_vcmd_t          vcmd;
  logic [LEFT_W-1:0]  v_left;
  logic [AMP_W-1:0]   v_amp;
  logic               v_msb;

  assign in_acc     = in_tvalid && in_tready;
  assign cfg_acc    = cfg_valid && cfg_ready;
  assign out_free   = !out_valid_r || out_tready;
  assign vidx_last  = (vidx_r == VIDX_W'(VOICE_COUNT - 1));
  assign fifo_full  = (count_r == CNT_W'(FIFO_DEPTH));
  assign fifo_empty = (count_r == '0);
  assign tone_ok    = active_r && (freq_r != '0) && (dur_r != '0);

  assign cfg_vol_in = (cfg_data[VOL_W-1:0] > VOL_W'(VOL_MAX)) ? VOL_W'(VOL_MAX)
                                                              : cfg_data[VOL_W-1:0];

  // A clear item, a volume of zero or a change of the active flag empties
  // the FIFO and all voices.
  assign empty_go = (state_r == ST_DECODE && op_r == OP_CLEAR) ||
                    (cfg_acc && cfg_index == CFG_VOLUME && cfg_vol_in == '0) ||
                    (cfg_acc && cfg_index == CFG_ACTIVE && cfg_data[0] != active_r);

  // Scaling works on the magnitude so the quotient truncates toward zero.
  assign pcm_mag  = pcm_r[SAMPLE_W-1] ? ((SAMPLE_W+1)'(0) - {1'b1, pcm_r})
                                      : {1'b0, pcm_r};
  assign push_q   = div_q[SAMPLE_W-1:0];
  assign push_val = pcm_r[SAMPLE_W-1] ? (SAMPLE_W'(0) - push_q) : push_q;

  assign tvol_clamp = (tvol_r > TVOL_W'(VOL_MAX)) ? VOL_W'(VOL_MAX) : tvol_r[VOL_W-1:0];
  assign len_sat    = (|div_q[DIV_W-1:LEFT_W]) ? {LEFT_W{1'b1}} : div_q[LEFT_W-1:0];

  assign amp_ext = $signed({{(MIX_W-AMP_W){1'b0}}, v_amp});
  assign contrib = v_msb ? amp_ext : -amp_ext;

  always_comb begin
    if (mix_r > $signed(MIX_W'(32767))) begin
      mix_clamped = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else if (mix_r < -$signed(MIX_W'(32768))) begin
      mix_clamped = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      mix_clamped = mix_r[SAMPLE_W-1:0];
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (op_r)
          OP_PUSH:  state_nxt = (active_r && !fifo_full) ? ST_PUSH_MUL : ST_FIN;
          OP_TONE:  state_nxt = tone_ok ? ST_TONE_SCAN : ST_FIN;
          OP_TICK:  state_nxt = ST_TICK_RD;
          default:  state_nxt = ST_FIN;
        endcase
      end
      ST_PUSH_MUL:   if (mul_done) state_nxt = ST_PUSH_DIV;
      ST_PUSH_DIV:   if (div_done) state_nxt = ST_PUSH_WR;
      ST_PUSH_WR:    state_nxt = ST_FIN;
      ST_TONE_SCAN:  if (vidx_last) state_nxt = ST_TONE_STEP;
      ST_TONE_STEP:  if (div_done) state_nxt = ST_TONE_LMUL;
      ST_TONE_LMUL:  if (mul_done) state_nxt = ST_TONE_LDIV;
      ST_TONE_LDIV:  if (div_done) state_nxt = ST_TONE_AMUL;
      ST_TONE_AMUL:  if (mul_done) state_nxt = ST_TONE_AMUL2;
      ST_TONE_AMUL2: if (mul_done) state_nxt = ST_TONE_ADIV;
      ST_TONE_ADIV:  if (div_done) state_nxt = ST_TONE_WR;
      ST_TONE_WR:    state_nxt = ST_FIN;
      ST_TICK_RD:    state_nxt = ST_TICK_LD;
      ST_TICK_LD:    state_nxt = ST_TICK_MIX;
      ST_TICK_MIX:   if (vidx_last) state_nxt = ST_FIN;
      ST_FIN:        if (out_free) state_nxt = ST_IDLE;
      default:       state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the controller. A unit is started on the edge that enters
  // the state which waits for it.
  always_comb begin
    in_tready = (state_r == ST_IDLE);
    cfg_ready = (state_r == ST_IDLE);
    mul_go    = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    mul_steps = '0;
    div_go    = 1'b0;
    div_n     = '0;
    div_d     = '0;
    div_steps = '0;
    case (state_nxt)
      ST_PUSH_MUL: begin
        mul_go    = (state_r != state_nxt);
        mul_a     = MUL_W'(pcm_mag);
        mul_b     = MUL_BW'(vol_r);
        mul_steps = MUL_CNT_W'(PUSH_MUL_STEPS);
      end
      ST_PUSH_DIV: begin
        div_go    = (state_r != state_nxt);
        div_n     = DIV_W'(mul_p) << (DIV_W - PUSH_DIV_STEPS);
        div_d     = DIVR_W'(PCT_DIV);
        div_steps = DIV_CNT_W'(PUSH_DIV_STEPS);
      end
      ST_TONE_STEP: begin
        div_go    = (state_r != state_nxt);
        div_n     = DIV_W'({freq_r, {PHASE_W{1'b0}}});
        div_d     = rate_r;
        div_steps = DIV_CNT_W'(STEP_DIV_STEPS);
      end
      ST_TONE_LMUL: begin
        mul_go    = (state_r != state_nxt);
        mul_a     = MUL_W'(dur_r);
        mul_b     = MUL_BW'(rate_r);
        mul_steps = MUL_CNT_W'(LEN_MUL_STEPS);
      end
      ST_TONE_LDIV: begin
        div_go    = (state_r != state_nxt);
        div_n     = DIV_W'(mul_p) << (DIV_W - LEN_DIV_STEPS);
        div_d     = DIVR_W'(MS_PER_S);
        div_steps = DIV_CNT_W'(LEN_DIV_STEPS);
      end
      ST_TONE_AMUL: begin
        mul_go    = (state_r != state_nxt);
        mul_a     = MUL_W'(vol_r);
        mul_b     = MUL_BW'(tvol_clamp);
        mul_steps = MUL_CNT_W'(AMP_MUL_STEPS);
      end
      ST_TONE_AMUL2: begin
        mul_go    = (state_r != state_nxt);
        mul_a     = mul_p;
        mul_b     = MUL_BW'(AMP_BASE);
        mul_steps = MUL_CNT_W'(AMP_MUL2_STEPS);
      end
      ST_TONE_ADIV: begin
        div_go    = (state_r != state_nxt);
        div_n     = DIV_W'(mul_p) << (DIV_W - AMP_DIV_STEPS);
        div_d     = DIVR_W'(AMP_DIV);
        div_steps = DIV_CNT_W'(AMP_DIV_STEPS);
      end
      default: begin
        mul_go = 1'b0;
      end
    endcase
  end

  assign ram_we = (state_r == ST_PUSH_WR);
  assign ram_re = (state_r == ST_TICK_RD) && !fifo_empty;

  always_comb begin
    vcmd        = '0;
    vcmd.clear  = empty_go;
    vcmd.load   = (state_r == ST_TONE_WR);
    vcmd.tick   = (state_r == ST_TICK_MIX) && (v_left != '0);
    vcmd.rd_idx = vidx_r;
    vcmd.wr_idx = sel_r;
    vcmd.step   = (rate_r == '0) ? '0 : step_res_r;
    vcmd.left   = len_res_r;
    vcmd.amp    = div_q[AMP_W-1:0];
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      vol_r       <= VOL_W'(VOL_RESET);
      rate_r      <= RATE_W'(RATE_RESET);
      active_r    <= 1'b0;
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      count_r     <= '0;
      vidx_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_acc) begin
        case (cfg_index)
          CFG_VOLUME: vol_r    <= cfg_vol_in;
          CFG_RATE:   rate_r   <= cfg_data[RATE_W-1:0];
          CFG_ACTIVE: active_r <= cfg_data[0];
          default:    vol_r    <= vol_r;
        endcase
      end

      if (empty_go) begin
        rd_ptr_r <= '0;
        wr_ptr_r <= '0;
        count_r  <= '0;
      end else if (state_r == ST_PUSH_WR) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
        count_r  <= count_r + 1'b1;
      end else if (ram_re) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
        count_r  <= count_r - 1'b1;
      end

      if (state_r == ST_DECODE) begin
        vidx_r <= '0;
      end else if (state_r == ST_TONE_SCAN || state_r == ST_TICK_MIX) begin
        vidx_r <= vidx_last ? '0 : vidx_r + 1'b1;
      end

      if (state_r == ST_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Item payload and intermediate results.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r   <= svm_op_t'(in_tuser);
      pcm_r  <= in_tdata[SAMPLE_W-1:0];
      freq_r <= in_tdata[SAMPLE_W +: FREQ_W];
      dur_r  <= in_tdata[SAMPLE_W+FREQ_W +: DUR_W];
      tvol_r <= in_tdata[SAMPLE_W+FREQ_W+DUR_W +: TVOL_W];
    end

    case (state_r)
      ST_DECODE: begin
        mix_r      <= '0;
        res_acc_r  <= 1'b0;
        res_used_r <= '0;
      end
      ST_PUSH_WR: begin
        res_acc_r <= 1'b1;
      end
      ST_TONE_SCAN: begin
        // Ties go to the earlier voice, an idle voice always wins, so the
        // last idle voice is kept.
        if (vidx_r == '0 || v_left == '0 || v_left < best_r) begin
          sel_r  <= vidx_r;
          best_r <= v_left;
        end
      end
      ST_TONE_STEP: begin
        if (div_done) begin
          step_res_r <= div_q[PHASE_W-1:0];
        end
      end
      ST_TONE_LDIV: begin
        if (div_done) begin
          len_res_r <= len_sat;
        end
      end
      ST_TONE_WR: begin
        res_acc_r  <= 1'b1;
        res_used_r <= USED_W'(sel_r);
      end
      ST_TICK_RD: begin
        had_r <= !fifo_empty;
      end
      ST_TICK_LD: begin
        mix_r <= had_r ? MIX_W'($signed(ram_q)) : '0;
      end
      ST_TICK_MIX: begin
        if (v_left != '0) begin
          mix_r <= mix_r + contrib;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_data_r <= OUT_DATA_W'({count_r, res_used_r, res_acc_r, mix_clamped});
        end
      end
      default: begin
        had_r <= had_r;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  svm_sermul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_go),
    .a     (mul_a),
    .b     (mul_b),
    .steps (mul_steps),
    .done  (mul_done),
    .prod  (mul_p)
  );

  svm_serdiv u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_go),
    .dividend (div_n),
    .divisor  (div_d),
    .steps    (div_steps),
    .done     (div_done),
    .quot     (div_q)
  );

  svm_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_ptr_r),
    .wdata (push_val),
    .re    (ram_re),
    .raddr (rd_ptr_r),
    .rdata (ram_q)
  );

  svm_voices u_voices (
    .clk     (clk),
    .rst_n   (rst_n),
    .vcmd    (vcmd),
    .rd_left (v_left),
    .rd_amp  (v_amp),
    .rd_msb  (v_msb)
  );

  `SVM_ASSERT_IMP(a_level_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(FIFO_DEPTH),
                  "fifo level above depth")
  `SVM_ASSERT_IMP(a_ptr_gap, clk, rst_n, 1'b1,
                  (wr_ptr_r - rd_ptr_r) == count_r[PTR_W-1:0],
                  "fifo pointers disagree with level")
  `SVM_ASSERT_IMP(a_push_room, clk, rst_n, state_r == ST_PUSH_WR, !fifo_full,
                  "push written into a full fifo")
  `SVM_ASSERT_IMP(a_mul_owner, clk, rst_n, mul_done,
                  state_r == ST_PUSH_MUL || state_r == ST_TONE_LMUL ||
                  state_r == ST_TONE_AMUL || state_r == ST_TONE_AMUL2,
                  "multiplier finished outside a multiply state")
  `SVM_ASSERT_NXT(a_result_loaded, clk, rst_n, state_r == ST_FIN && out_free,
                  out_valid_r && state_r == ST_IDLE,
                  "finished item did not reach the output register")

endmodule

// ===== hdl/svm_ram.sv =====
module svm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

// ===== hdl/svm_sermul.sv =====
module svm_sermul (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [svm_pkg::MUL_W-1:0]      a,
  input  logic [svm_pkg::MUL_BW-1:0]     b,
  input  logic [svm_pkg::MUL_CNT_W-1:0]  steps,
  output logic                           done,
  output logic [svm_pkg::MUL_W-1:0]      prod
);
  import svm_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [MUL_CNT_W-1:0] cnt_r;
  logic [MUL_W-1:0]     a_r;
  logic [MUL_BW-1:0]    b_r;
  logic [MUL_W-1:0]     p_r;

  // One multiplier bit per cycle, least significant first.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= steps;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == MUL_CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
      p_r <= '0;
    end else if (busy_r) begin
      if (b_r[0]) begin
        p_r <= p_r + a_r;
      end
      a_r <= {a_r[MUL_W-2:0], 1'b0};
      b_r <= {1'b0, b_r[MUL_BW-1:1]};
    end
  end

  assign done = done_r;
  assign prod = p_r;

endmodule

// ===== hdl/svm_serdiv.sv =====
module svm_serdiv (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [svm_pkg::DIV_W-1:0]      dividend,
  input  logic [svm_pkg::DIVR_W-1:0]     divisor,
  input  logic [svm_pkg::DIV_CNT_W-1:0]  steps,
  output logic                           done,
  output logic [svm_pkg::DIV_W-1:0]      quot
);
  import svm_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIVR_W-1:0]    d_r;
  logic [DIVR_W-1:0]    rem_r;
  logic [DIV_W-1:0]     q_r;
  logic [DIVR_W:0]      trial;
  logic [DIVR_W+1:0]    diff;
  logic                 fits;

  // Restoring division: the dividend is left aligned, so after the given
  // number of steps its bits have all been replaced by quotient bits.
  assign trial = {rem_r, q_r[DIV_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, d_r};
  assign fits  = !diff[DIVR_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= steps;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      d_r   <= divisor;
      rem_r <= '0;
      q_r   <= dividend;
    end else if (busy_r) begin
      rem_r <= fits ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
      q_r   <= {q_r[DIV_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

// ===== hdl/svm_voices.sv =====
module svm_voices (
  input  logic                       clk,
  input  logic                       rst_n,
  input  svm_pkg::svm_vcmd_t         vcmd,
  output logic [svm_pkg::LEFT_W-1:0] rd_left,
  output logic [svm_pkg::AMP_W-1:0]  rd_amp,
  output logic                       rd_msb
);
  import svm_pkg::*;

  logic [PHASE_W-1:0] phase_r [VOICE_COUNT];
  logic [PHASE_W-1:0] step_r  [VOICE_COUNT];
  logic [LEFT_W-1:0]  left_r  [VOICE_COUNT];
  logic [AMP_W-1:0]   amp_r   [VOICE_COUNT];

  // A voice with nothing left is silent, so clearing the counts is enough;
  // a load rewrites every field of the chosen voice.
  always_ff @(posedge clk) begin
    if (!rst_n || vcmd.clear) begin
      for (int i = 0; i < VOICE_COUNT; i++) begin
        left_r[i] <= '0;
      end
    end else if (vcmd.load) begin
      left_r[vcmd.wr_idx] <= vcmd.left;
    end else if (vcmd.tick) begin
      left_r[vcmd.rd_idx] <= left_r[vcmd.rd_idx] - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (vcmd.load) begin
      phase_r[vcmd.wr_idx] <= '0;
      step_r[vcmd.wr_idx]  <= vcmd.step;
      amp_r[vcmd.wr_idx]   <= vcmd.amp;
    end else if (vcmd.tick) begin
      phase_r[vcmd.rd_idx] <= phase_r[vcmd.rd_idx] + step_r[vcmd.rd_idx];
    end
  end

  assign rd_left = left_r[vcmd.rd_idx];
  assign rd_amp  = amp_r[vcmd.rd_idx];
  assign rd_msb  = phase_r[vcmd.rd_idx][PHASE_W-1];

endmodule

// ===== tb/tb_square_voice_pcm_mixer_top.sv =====
module tb_square_voice_pcm_mixer_top;
  timeunit 1ns;
  timeprecision 1ps;

  import svm_pkg::*;

  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int LONG_HOLD   = 600;
  localparam int TAIL_CYCLES = 200;
  localparam int PHASES      = 8;
  localparam int VOL_SET [PHASES]  = '{100, 1, 73, 127, 50, 99, 100, 37};
  localparam int RATE_SET [PHASES] = '{16000, 8000, 48000, 44100, 65535, 0, 22050, 11025};

  // Same bit order as out_tdata: the first member lands in the top bits.
  typedef struct packed {
    logic [12:0] level;
    logic [1:0]  voice;
    logic        accepted;
    logic [15:0] mixed;
  } mix_word_t;

  class mixer_scoreboard;
    logic [15:0] pcm_mem [FIFO_DEPTH];
    int unsigned rd_ptr, wr_ptr, level;
    bit [31:0]   v_phase [VOICE_COUNT];
    bit [31:0]   v_step [VOICE_COUNT];
    int unsigned v_left [VOICE_COUNT];
    int          v_amp [VOICE_COUNT];
    int unsigned volume, rate;
    bit          active;
    mix_word_t   words_due [$];
    int          errors;

    function new();
      volume = 50;
      rate = 16000;
      active = 1'b0;
      errors = 0;
      empty_audio();
    endfunction

    function void empty_audio();
      rd_ptr = 0;
      wr_ptr = 0;
      level = 0;
      for (int v = 0; v < VOICE_COUNT; v++) begin
        v_phase[v] = '0;
        v_step[v] = '0;
        v_left[v] = 0;
        v_amp[v] = 0;
      end
    endfunction

    function void write_reg(svm_cfg_idx_t idx, logic [15:0] data);
      int unsigned vol;
      case (idx)
        CFG_VOLUME: begin
          vol = data[6:0];
          if (vol > 100) vol = 100;
          volume = vol;
          if (vol == 0) empty_audio();
        end
        CFG_RATE: rate = data;
        CFG_ACTIVE: begin
          if (data[0] != active) empty_audio();
          active = data[0];
        end
        default: ;
      endcase
    endfunction

    function void take_item(svm_op_t op, logic [IN_DATA_W-1:0] data);
      mix_word_t   want;
      int          mixed;
      int          sample;
      int          scaled;
      int unsigned freq, dur, tvol, sel;
      longint unsigned len;
      bit [63:0]   quot;
      want = '0;
      mixed = 0;
      case (op)
        OP_PUSH: begin
          if (active && level < FIFO_DEPTH) begin
            sample = $signed(data[15:0]);
            scaled = (sample * int'(volume)) / 100;
            pcm_mem[wr_ptr] = scaled[15:0];
            wr_ptr = (wr_ptr + 1) % FIFO_DEPTH;
            level++;
            want.accepted = 1'b1;
          end
        end
        OP_TONE: begin
          freq = data[31:16];
          dur = data[47:32];
          tvol = data[55:48];
          if (active && freq != 0 && dur != 0) begin
            if (tvol > 100) tvol = 100;
            sel = 0;
            // An idle voice always wins; the last idle one found is kept.
            for (int v = 0; v < VOICE_COUNT; v++) begin
              if (v_left[v] == 0 || v_left[v] < v_left[sel]) sel = v;
            end
            v_phase[sel] = '0;
            if (rate == 0) begin
              v_step[sel] = '0;
            end else begin
              quot = {32'(freq), 32'd0} / 64'(rate);
              v_step[sel] = quot[31:0];
            end
            len = (longint'(dur) * rate) / 1000;
            v_left[sel] = (len > 64'h3F_FFFF) ? 32'h3F_FFFF : 32'(len);
            v_amp[sel] = int'((6553 * volume * tvol) / 10000);
            want.accepted = 1'b1;
            want.voice = sel[1:0];
          end
        end
        OP_TICK: begin
          if (level > 0) begin
            mixed = $signed(pcm_mem[rd_ptr]);
            rd_ptr = (rd_ptr + 1) % FIFO_DEPTH;
            level--;
          end
          for (int v = 0; v < VOICE_COUNT; v++) begin
            if (v_left[v] != 0) begin
              mixed += v_phase[v][31] ? v_amp[v] : -v_amp[v];
              v_phase[v] += v_step[v];
              v_left[v]--;
            end
          end
          if (mixed > 32767) mixed = 32767;
          if (mixed < -32768) mixed = -32768;
          want.mixed = mixed[15:0];
        end
        default: empty_audio();
      endcase
      want.level = level[12:0];
      words_due.push_back(want);
    endfunction

    function void check_word(logic [OUT_DATA_W-1:0] word);
      mix_word_t want;
      mix_word_t got;
      got = word;
      if (words_due.size() == 0) begin
        $error("result word %h arrived with nothing expected", word);
        errors++;
        return;
      end
      want = words_due.pop_front();
      if (got.mixed !== want.mixed) begin
        $error("mixed_sample: expected %0d, got %0d", $signed(want.mixed), $signed(got.mixed));
        errors++;
      end
      if (got.accepted !== want.accepted) begin
        $error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
        errors++;
      end
      if (got.voice !== want.voice) begin
        $error("voice_used: expected %0d, got %0d", want.voice, got.voice);
        errors++;
      end
      if (got.level !== want.level) begin
        $error("fifo_level: expected %0d, got %0d", want.level, got.level);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [OP_W-1:0]       in_tuser = '0;
  logic                  out_tready = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  wire                   in_tready;
  wire                   out_tvalid;
  wire                   cfg_ready;
  wire [OUT_DATA_W-1:0]  out_tdata;

  mixer_scoreboard sb = new();
  int unsigned     cycles = 0;
  int              results_seen = 0;
  int              burst_left = 0;
  bit              no_gaps = 1'b0;

  square_voice_pcm_mixer_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Words leaving are checked before the word entering at the same edge is predicted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        sb.check_word(out_tdata);
        results_seen++;
      end
      if (in_tvalid && in_tready) sb.take_item(svm_op_t'(in_tuser), in_tdata);
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("square_voice_pcm_mixer_top test failed");
    $finish;
  end

  // Receiver: stall patterns that change every so often, plus one long hold-off
  // taken while the sender is offering, so the block backs up into its input.
  initial begin
    int  mode;
    int  span;
    int  phase_cnt;
    bit  held;
    mode = 0;
    span = 0;
    phase_cnt = 0;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && results_seen >= 300 && in_tvalid) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      if (span == 0) begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(20, 200);
      end
      span--;
      phase_cnt++;
      case (mode)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(0, 1));
        2: out_tready <= (phase_cnt % 3 == 0);
        default: out_tready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  task automatic send_item(svm_op_t op, logic [IN_DATA_W-1:0] data);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = no_gaps ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= data;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_op(svm_op_t op);
    send_item(op, IN_DATA_W'({$urandom, $urandom}));
  endtask

  task automatic push_sample(logic [15:0] s);
    send_item(OP_PUSH, {40'({$urandom, $urandom}), s});
  endtask

  task automatic start_tone(logic [15:0] f, logic [15:0] d, logic [7:0] v);
    send_item(OP_TONE, {v, d, f, 16'($urandom)});
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.words_due.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Registers change only with the block idle and every word back.
  task automatic set_reg(svm_cfg_idx_t idx, logic [15:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_item();
    int          r;
    int          k;
    logic [15:0] f;
    logic [15:0] d;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      k = $urandom_range(0, 19);
      case (k)
        0: push_sample(16'h7FFF);
        1: push_sample(16'h8000);
        2: push_sample(16'hFFFF);
        3: push_sample(16'h0000);
        default: push_sample(16'($urandom));
      endcase
    end else if (r < 55) begin
      k = $urandom_range(0, 19);
      f = (k == 0) ? 16'd0 : (k < 3) ? 16'($urandom) : 16'($urandom_range(20, 4000));
      k = $urandom_range(0, 19);
      d = (k == 0) ? 16'd0 : (k < 2) ? 16'($urandom) : 16'($urandom_range(1, 12));
      start_tone(f, d, 8'($urandom_range(0, 255)));
    end else if (r < 98) begin
      send_op(OP_TICK);
    end else begin
      send_op(OP_CLEAR);
    end
  endtask

  task automatic run_random(int n);
    no_gaps = ($urandom_range(0, 3) == 0);
    repeat (n) random_item();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Audio off: pushes and tones are refused, a tick gives silence.
    push_sample(16'd1000);
    start_tone(16'd440, 16'd100, 8'd50);
    send_op(OP_TICK);

    set_reg(CFG_ACTIVE, 16'd1);
    push_sample(16'h7FFF);
    push_sample(16'h8000);
    push_sample(16'hFFFF);
    // Only the low seven bits count, so this sets full volume.
    set_reg(CFG_VOLUME, 16'hFFE4);
    push_sample(16'h7FFF);
    push_sample(16'h8000);
    start_tone(16'd0, 16'd10, 8'd50);
    start_tone(16'd1000, 16'd0, 8'd50);
    start_tone(16'hFFFF, 16'hFFFF, 8'hFF);
    start_tone(16'd1000, 16'd3, 8'd100);
    start_tone(16'd1, 16'd1, 8'd0);
    start_tone(16'd2000, 16'd2, 8'd101);
    // All voices busy: the one with the fewest samples left is taken.
    start_tone(16'd500, 16'd1, 8'd50);
    repeat (5) send_op(OP_TICK);
    send_op(OP_CLEAR);
    send_op(OP_TICK);

    // A zero rate accepts the tone but leaves the voice silent.
    set_reg(CFG_RATE, 16'd0);
    start_tone(16'd1000, 16'd10, 8'd50);
    send_op(OP_TICK);
    // Long tone at the top rate saturates the sample count.
    set_reg(CFG_RATE, 16'hFFFF);
    start_tone(16'd500, 16'hFFFF, 8'd100);
    send_op(OP_TICK);

    for (int i = 0; i < PHASES; i++) begin
      if (i == 3) set_reg(CFG_VOLUME, 16'd0);
      set_reg(CFG_VOLUME, 16'(VOL_SET[i]));
      set_reg(CFG_RATE, 16'(RATE_SET[i]));
      if (i == 5) begin
        set_reg(CFG_ACTIVE, 16'd0);
        run_random(30);
      end
      set_reg(CFG_ACTIVE, 16'd1);
      run_random(110);
    end

    // Let samples pile up in the FIFO, then pop them with a tone mixed in.
    set_reg(CFG_VOLUME, 16'd100);
    set_reg(CFG_RATE, 16'd16000);
    set_reg(CFG_ACTIVE, 16'd0);
    set_reg(CFG_ACTIVE, 16'd1);
    no_gaps = 1'b0;
    repeat (60) push_sample(16'($urandom));
    repeat (30) send_op(OP_TICK);
    start_tone(16'd3000, 16'd5, 8'd80);
    repeat (20) send_op(OP_TICK);
    send_op(OP_CLEAR);
    send_op(OP_TICK);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.words_due.size() == 0) begin
      $display("square_voice_pcm_mixer_top test passed");
    end else begin
      $display("square_voice_pcm_mixer_top test failed");
    end
    $finish;
  end

endmodule
